[rtl/core/framebuffer_line_rasterizer_unit_macros.svh]
// Assertion macros shared by the framebuffer line rasterizer.
`ifndef FRAMEBUFFER_LINE_RASTERIZER_UNIT_MACROS_SVH
`define FRAMEBUFFER_LINE_RASTERIZER_UNIT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define FLR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define FLR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/flr_pkg.sv]
package flr_pkg;

	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;

	localparam int COORD_W     = 12;
	localparam int IN_DATA_W   = 64;
	localparam int IN_USER_W   = 3;
	localparam int OUT_DATA_W  = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [IN_USER_W-1:0] REQ_SET_PIXEL = 3'd0;
	localparam logic [IN_USER_W-1:0] REQ_DRAW_LINE = 3'd1;
	localparam logic [IN_USER_W-1:0] REQ_CLEAR     = 3'd2;
	localparam logic [IN_USER_W-1:0] REQ_SWAP      = 3'd3;
	localparam logic [IN_USER_W-1:0] REQ_READ      = 3'd4;

	typedef enum logic [2:0] {
		OP_PIXEL,
		OP_LINE,
		OP_CLEAR,
		OP_SWAP,
		OP_READ,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic signed [COORD_W-1:0]  x0;
		logic signed [COORD_W-1:0]  y0;
		logic signed [COORD_W-1:0]  x1;
		logic signed [COORD_W-1:0]  y1;
		logic [COORD_W-1:0]         adx;
		logic [COORD_W-1:0]         ady;
		logic                       sx_neg;
		logic                       sy_neg;
		logic [6:0]                 rd_col;
		logic [2:0]                 rd_page;
		logic                       rd_ok;
	} cmd_t;

endpackage

[rtl/core/framebuffer_line_rasterizer_unit.sv]
// Channel  Direction  Fields (lowest bit first)
// s_*      in         tuser: req_type; tdata: x_start, y_start, x_end, y_end,
//                     read_column, read_page, zero fill to 64 bits
// m_*      out        tdata: read_data
//
// Every word gives exactly one result word, in order. A set pixel reads and then
// writes one memory byte, a line reads and writes a byte for each pixel walked after
// a setup step, a clear writes each memory entry of a buffer (1024 by default), a read
// does one memory read, and a swap or an unused code goes straight to its result. The
// read-modify-write of each pixel in the frame memory sets the line rate. After reset
// a clearing pass over every memory entry (2048 by default) runs with s_tready low.
// A two-word queue and the output register let each side stall alone.
`include "framebuffer_line_rasterizer_unit_macros.svh"

module framebuffer_line_rasterizer_unit import flr_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // x_start, y_start, x_end, y_end, read_column, read_page
	input  logic [IN_USER_W-1:0]  s_tuser,   // req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // read_data
);

	logic init_done;
	logic q_full;
	logic push;
	cmd_t cmd;
	logic pop;
	logic head_valid;
	cmd_t head;

	flr_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.init_done (init_done),
		.q_full    (q_full),
		.push      (push),
		.cmd       (cmd)
	);

	flr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.cmd        (cmd),
		.q_full     (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	flr_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.init_done  (init_done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	`FLR_ASSERT_NOW(a_init_blocks_input, !init_done, !s_tready, "word accepted during clearing pass")
	`FLR_ASSERT_NOW(a_init_no_result, !init_done, !m_tvalid, "result shown during clearing pass")
	`FLR_ASSERT_NOW(a_pop_has_entry, pop, head_valid, "queue popped while empty")
	`FLR_ASSERT_NEXT(a_one_item_at_work, pop, !pop, "second word taken while one is at work")

endmodule

[rtl/core/flr_front.sv]
module flr_front import flr_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic [IN_USER_W-1:0] s_tuser,
	input  logic                 init_done,
	input  logic                 q_full,
	output logic                 push,
	output cmd_t                 cmd
);

	localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;

	logic signed [COORD_W:0] dx;
	logic signed [COORD_W:0] dy;
	logic signed [COORD_W:0] ndx;
	logic signed [COORD_W:0] ndy;

	assign s_tready = init_done && !q_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		cmd.x0      = s_tdata[11:0];
		cmd.y0      = s_tdata[23:12];
		cmd.x1      = s_tdata[35:24];
		cmd.y1      = s_tdata[47:36];
		cmd.rd_col  = s_tdata[54:48];
		cmd.rd_page = s_tdata[57:55];

		dx  = {cmd.x1[COORD_W-1], cmd.x1} - {cmd.x0[COORD_W-1], cmd.x0};
		dy  = {cmd.y1[COORD_W-1], cmd.y1} - {cmd.y0[COORD_W-1], cmd.y0};
		ndx = -dx;
		ndy = -dy;
		cmd.sx_neg = dx[COORD_W];
		cmd.sy_neg = dy[COORD_W];
		cmd.adx    = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
		cmd.ady    = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];

		cmd.rd_ok = (int'(cmd.rd_col) < SCREEN_WIDTH) && (int'(cmd.rd_page) < PAGE_COUNT);

		unique case (s_tuser)
			REQ_SET_PIXEL: cmd.op = OP_PIXEL;
			REQ_DRAW_LINE: cmd.op = OP_LINE;
			REQ_CLEAR:     cmd.op = OP_CLEAR;
			REQ_SWAP:      cmd.op = OP_SWAP;
			REQ_READ:      cmd.op = OP_READ;
			default:       cmd.op = OP_NONE;
		endcase
	end

endmodule

[rtl/core/flr_queue.sv]
module flr_queue import flr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t cmd,
	output logic q_full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign q_full     = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cmd;
		end
	end

endmodule

[rtl/core/flr_back.sv]
module flr_back import flr_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  cmd_t                  head,
	output logic                  pop,
	output logic                  init_done,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
	localparam int COL_W      = $clog2(SCREEN_WIDTH);
	localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int ADDR_W     = 1 + COL_W + PAGE_W;
	localparam int DEPTH      = 1 << ADDR_W;
	localparam int ERR_W      = 16;

	typedef enum logic [7:0] {
		ST_INIT    = 8'b0000_0001,
		ST_IDLE    = 8'b0000_0010,
		ST_SETUP   = 8'b0000_0100,
		ST_PLOT_RD = 8'b0000_1000,
		ST_PLOT_WR = 8'b0001_0000,
		ST_CLEAR   = 8'b0010_0000,
		ST_READ    = 8'b0100_0000,
		ST_RESP    = 8'b1000_0000
	} state_t;

	state_t                    state_q;
	cmd_t                      cmd_q;
	logic                      buf_q;
	logic [ADDR_W-1:0]         clr_q;
	logic signed [COORD_W-1:0] cur_x_q;
	logic signed [COORD_W-1:0] cur_y_q;
	logic                      line_q;
	logic                      major_x_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [ERR_W-1:0]   inc_min_q;
	logic signed [ERR_W-1:0]   inc_diag_q;
	logic                      on_q;
	logic [ADDR_W-1:0]         addr_q;
	logic [7:0]                mask_q;
	logic [OUT_DATA_W-1:0]     res_q;
	logic                      m_tvalid_q;
	logic [OUT_DATA_W-1:0]     m_tdata_q;

	logic [7:0]                mem [DEPTH];
	logic [7:0]                rd_data_q;

	logic                      mem_we;
	logic [ADDR_W-1:0]         mem_wa;
	logic [7:0]                mem_wd;
	logic                      mem_re;
	logic [ADDR_W-1:0]         mem_ra;

	logic                      setup_major_x;
	logic [COORD_W-1:0]        setup_maj;
	logic [COORD_W-1:0]        setup_min;
	logic signed [ERR_W-1:0]   maj_e;
	logic signed [ERR_W-1:0]   min_e;
	logic signed [COORD_W-1:0] maj_cur;
	logic signed [COORD_W-1:0] maj_end;
	logic                      on_screen;
	logic [ADDR_W-1:0]         pix_addr;
	logic                      err_neg;
	logic                      out_free;

	assign init_done = (state_q != ST_INIT);
	assign pop       = (state_q == ST_IDLE) && head_valid;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		setup_major_x = (cmd_q.adx > cmd_q.ady);
		setup_maj     = setup_major_x ? cmd_q.adx : cmd_q.ady;
		setup_min     = setup_major_x ? cmd_q.ady : cmd_q.adx;
		maj_e         = ERR_W'(setup_maj);
		min_e         = ERR_W'(setup_min);

		maj_cur = major_x_q ? cur_x_q : cur_y_q;
		maj_end = major_x_q ? cmd_q.x1 : cmd_q.y1;

		on_screen = !cur_x_q[COORD_W-1] && (int'(cur_x_q) < SCREEN_WIDTH) &&
			!cur_y_q[COORD_W-1] && (int'(cur_y_q) < SCREEN_HEIGHT);
		pix_addr  = {buf_q, cur_x_q[COL_W-1:0], cur_y_q[PAGE_W+2:3]};
		err_neg   = err_q[ERR_W-1];

		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = rd_data_q | mask_q;
		mem_re = 1'b0;
		mem_ra = pix_addr;
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = {buf_q, clr_q[ADDR_W-2:0]};
				mem_wd = '0;
			end
			ST_PLOT_WR: begin
				mem_we = on_q;
			end
			ST_PLOT_RD: begin
				mem_re = 1'b1;
			end
			ST_IDLE: begin
				mem_re = head_valid && (head.op == OP_READ);
				mem_ra = {buf_q, COL_W'(head.rd_col), PAGE_W'(head.rd_page)};
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			buf_q      <= 1'b0;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESP && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head_valid) begin
						unique case (head.op)
							OP_PIXEL: state_q <= ST_PLOT_RD;
							OP_LINE:  state_q <= ST_SETUP;
							OP_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							OP_SWAP: begin
								buf_q   <= !buf_q;
								state_q <= ST_RESP;
							end
							OP_READ:  state_q <= ST_READ;
							default:  state_q <= ST_RESP;
						endcase
					end
				end
				ST_SETUP: begin
					state_q <= ST_PLOT_RD;
				end
				ST_PLOT_RD: begin
					if (line_q && (maj_cur == maj_end)) begin
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_PLOT_WR;
					end
				end
				ST_PLOT_WR: begin
					state_q <= line_q ? ST_PLOT_RD : ST_RESP;
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q[ADDR_W-2:0] == '1) begin
						state_q <= ST_RESP;
					end
				end
				ST_READ: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			m_tdata_q <= res_q;
		end
		if (pop) begin
			cmd_q   <= head;
			cur_x_q <= head.x0;
			cur_y_q <= head.y0;
			line_q  <= 1'b0;
			res_q   <= '0;
		end
		if (state_q == ST_READ) begin
			res_q <= cmd_q.rd_ok ? rd_data_q : '0;
		end
		if (state_q == ST_SETUP) begin
			line_q     <= 1'b1;
			major_x_q  <= setup_major_x;
			err_q      <= (min_e <<< 1) - maj_e;
			inc_min_q  <= min_e <<< 1;
			inc_diag_q <= (min_e - maj_e) <<< 1;
		end
		if (state_q == ST_PLOT_RD) begin
			on_q   <= on_screen;
			addr_q <= pix_addr;
			mask_q <= 8'b1 << cur_y_q[2:0];
		end
		if (state_q == ST_PLOT_WR && line_q) begin
			err_q <= err_q + (err_neg ? inc_min_q : inc_diag_q);
			if (major_x_q || !err_neg) begin
				cur_x_q <= cmd_q.sx_neg ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
			end
			if (!major_x_q || !err_neg) begin
				cur_y_q <= cmd_q.sy_neg ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
			end
		end
	end

endmodule

[bench/tb_framebuffer_line_rasterizer_unit.sv]
module tb_framebuffer_line_rasterizer_unit;
	import flr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGES     = (SCREEN_HEIGHT_DEF + 7) / 8;
	localparam int BUF_BYTES = SCREEN_WIDTH_DEF * PAGES;

	localparam logic [IN_USER_W-1:0] REQ_SPARE_A = 3'd5;
	localparam logic [IN_USER_W-1:0] REQ_SPARE_B = 3'd6;
	localparam logic [IN_USER_W-1:0] REQ_SPARE_C = 3'd7;

	typedef struct {
		logic [IN_USER_W-1:0]      kind;
		logic signed [COORD_W-1:0] xs;
		logic signed [COORD_W-1:0] ys;
		logic signed [COORD_W-1:0] xe;
		logic signed [COORD_W-1:0] ye;
		logic [6:0]                col;
		logic [2:0]                page;
	} fb_request_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // x_start, y_start, x_end, y_end, read_column, read_page
	logic [IN_USER_W-1:0]  s_tuser = '0;   // req_type
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // read_data

	logic [7:0] frame_bytes [0:2*BUF_BYTES-1];
	logic       front_buffer;
	logic [7:0] expected_read_data [$];

	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int last_col = 0;
	int last_page = 0;

	framebuffer_line_rasterizer_unit #(
		.SCREEN_WIDTH (SCREEN_WIDTH_DEF),
		.SCREEN_HEIGHT(SCREEN_HEIGHT_DEF)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	// The receiver counts down a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_read_data.size() == 0) begin
				$error("read_data: unexpected word, actual %02h", m_tdata);
				fail_count++;
			end else begin
				if (m_tdata !== expected_read_data[0]) begin
					$error("read_data mismatch: expected %02h, actual %02h",
						expected_read_data[0], m_tdata);
					fail_count++;
				end
				void'(expected_read_data.pop_front());
			end
		end
	end

	function automatic void plot_pixel(int x, int y);
		int idx;
		if (x < 0 || y < 0 || x >= SCREEN_WIDTH_DEF || y >= SCREEN_HEIGHT_DEF)
			return;
		idx = int'(front_buffer) * BUF_BYTES + x * PAGES + (y >> 3);
		frame_bytes[idx] = frame_bytes[idx] | (8'h01 << (y & 7));
	endfunction

	function automatic void rasterize_line(int xa, int ya, int xb, int yb);
		int dx, dy, sx, sy, err, x, y;
		dx = xb - xa;
		dy = yb - ya;
		sx = (dx >= 0) ? 1 : -1;
		sy = (dy >= 0) ? 1 : -1;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		if (dx > dy) begin
			err = 2 * dy - dx;
			y = ya;
			for (x = xa; x != xb; x += sx) begin
				plot_pixel(x, y);
				if (err >= 0) begin
					err -= 2 * dx;
					y += sy;
				end
				err += 2 * dy;
			end
		end else begin
			err = 2 * dx - dy;
			x = xa;
			for (y = ya; y != yb; y += sy) begin
				plot_pixel(x, y);
				if (err >= 0) begin
					err -= 2 * dy;
					x += sx;
				end
				err += 2 * dx;
			end
		end
	endfunction

	function automatic logic [7:0] render_and_read(fb_request_t r);
		int base;
		logic [7:0] data;
		base = int'(front_buffer) * BUF_BYTES;
		data = 8'h00;
		case (r.kind)
			REQ_SET_PIXEL: plot_pixel(int'(r.xs), int'(r.ys));
			REQ_DRAW_LINE: rasterize_line(int'(r.xs), int'(r.ys), int'(r.xe), int'(r.ye));
			REQ_CLEAR: begin
				for (int i = 0; i < BUF_BYTES; i++)
					frame_bytes[base + i] = 8'h00;
			end
			REQ_SWAP: front_buffer = ~front_buffer;
			REQ_READ: begin
				if (int'(r.col) < SCREEN_WIDTH_DEF && int'(r.page) < PAGES)
					data = frame_bytes[base + int'(r.col) * PAGES + int'(r.page)];
			end
			default: ;
		endcase
		return data;
	endfunction

	function automatic fb_request_t make_request(logic [IN_USER_W-1:0] kind, int xs, int ys,
		int xe, int ye, int col, int page);
		fb_request_t r;
		r.kind = kind;
		r.xs = xs[11:0];
		r.ys = ys[11:0];
		r.xe = xe[11:0];
		r.ye = ye[11:0];
		r.col = col[6:0];
		r.page = page[2:0];
		return r;
	endfunction

	task automatic send_request(fb_request_t r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.kind;
		s_tdata <= {6'b0, r.page, r.col, r.ye, r.xe, r.ys, r.xs};
		do @(posedge clk); while (!s_tready);
		expected_read_data.push_back(render_and_read(r));
	endtask

	task automatic stop_and_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_read_data.size() != 0)
			@(posedge clk);
	endtask

	function automatic int near_x();
		return int'($urandom_range(209)) - 40;
	endfunction

	function automatic int near_y();
		return int'($urandom_range(139)) - 40;
	endfunction

	function automatic void note_pixel(int x, int y);
		if (x >= 0 && y >= 0 && x < SCREEN_WIDTH_DEF && y < SCREEN_HEIGHT_DEF) begin
			last_col = x;
			last_page = y >> 3;
		end
	endfunction

	function automatic fb_request_t random_request();
		fb_request_t r;
		int pick;
		r = make_request(REQ_SPARE_A, $urandom_range(4095), $urandom_range(4095),
			$urandom_range(4095), $urandom_range(4095), $urandom_range(127),
			$urandom_range(7));
		pick = $urandom_range(99);
		if (pick < 22) begin
			r.kind = REQ_SET_PIXEL;
			if ($urandom_range(9) != 0) begin
				r.xs = 12'(near_x());
				r.ys = 12'(near_y());
			end
			note_pixel(int'(r.xs), int'(r.ys));
		end else if (pick < 52) begin
			r.kind = REQ_DRAW_LINE;
			if ($urandom_range(39) != 0) begin
				r.xs = 12'(near_x());
				r.ys = 12'(near_y());
				r.xe = 12'(near_x());
				r.ye = 12'(near_y());
			end
			note_pixel(int'(r.xs), int'(r.ys));
		end else if (pick < 87) begin
			r.kind = REQ_READ;
			if ($urandom_range(1) == 0) begin
				r.col = 7'(last_col);
				r.page = 3'(last_page);
			end
		end else if (pick < 90) begin
			r.kind = REQ_CLEAR;
		end else if (pick < 96) begin
			r.kind = REQ_SWAP;
		end else begin
			case ($urandom_range(2))
				0: r.kind = REQ_SPARE_A;
				1: r.kind = REQ_SPARE_B;
				default: r.kind = REQ_SPARE_C;
			endcase
		end
		return r;
	endfunction

	task automatic test_power_up_state();
		send_request(make_request(REQ_READ, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, 127, 7));
		stop_and_drain();
	endtask

	task automatic test_pixel_clipping();
		send_request(make_request(REQ_SET_PIXEL, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_SET_PIXEL, 127, 63, 0, 0, 0, 0));
		send_request(make_request(REQ_SET_PIXEL, -1, 5, 0, 0, 0, 0));
		send_request(make_request(REQ_SET_PIXEL, 128, 5, 0, 0, 0, 0));
		send_request(make_request(REQ_SET_PIXEL, 5, -1, 0, 0, 0, 0));
		send_request(make_request(REQ_SET_PIXEL, 5, 64, 0, 0, 0, 0));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, 127, 7));
		stop_and_drain();
	endtask

	task automatic test_line_shapes();
		send_request(make_request(REQ_DRAW_LINE, 10, 10, 10, 10, 0, 0));
		send_request(make_request(REQ_DRAW_LINE, 0, 20, 20, 25, 0, 0));
		send_request(make_request(REQ_DRAW_LINE, 60, 60, 55, 2, 0, 0));
		send_request(make_request(REQ_DRAW_LINE, -2048, -2048, 2047, 2047, 0, 0));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, 5, 2));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, 58, 3));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, 30, 3));
		stop_and_drain();
	endtask

	task automatic test_clear_and_swap();
		send_request(make_request(REQ_SWAP, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_SET_PIXEL, 10, 10, 0, 0, 0, 0));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, 10, 1));
		send_request(make_request(REQ_SWAP, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_SWAP, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, 10, 1));
		stop_and_drain();
	endtask

	task automatic test_spare_codes();
		send_request(make_request(REQ_SPARE_A, 3, 3, 40, 40, 0, 0));
		send_request(make_request(REQ_SPARE_B, 3, 3, 40, 40, 0, 0));
		send_request(make_request(REQ_SPARE_C, 3, 3, 40, 40, 0, 0));
		stop_and_drain();
	endtask

	task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_request(random_request());
		stop_and_drain();
	endtask

	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 600;
		repeat (30) begin
			if ($urandom_range(1) == 0)
				send_request(make_request(REQ_SET_PIXEL, $urandom_range(127),
					$urandom_range(63), 0, 0, 0, 0));
			else
				send_request(make_request(REQ_READ, 0, 0, 0, 0, $urandom_range(127),
					$urandom_range(7)));
		end
		stop_and_drain();
	endtask

	initial begin
		for (int i = 0; i < 2 * BUF_BYTES; i++)
			frame_bytes[i] = 8'h00;
		front_buffer = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_up_state();
		test_pixel_clipping();
		test_line_shapes();
		test_clear_and_swap();
		test_spare_codes();
		test_random_traffic(250, 0, 0);
		test_random_traffic(250, 46, 0);
		test_random_traffic(250, 0, 46);
		test_output_backpressure();
		test_random_traffic(250, 35, 35);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/flr_pkg.sv
rtl/core/flr_front.sv
rtl/core/flr_queue.sv
rtl/core/flr_back.sv
rtl/core/framebuffer_line_rasterizer_unit.sv
bench/tb_framebuffer_line_rasterizer_unit.sv
